// File: rtl/tlc_pkg.sv
package tlc_pkg;

    localparam int COUNT_BITS = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'd255;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = 8'd1;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] CFG_HOT_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_WARM_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_PROMOTE_THR = 2'd2;

    typedef enum logic [1:0] {
        LOP_SCAN,
        LOP_TOUCH,
        LOP_DROP,
        LOP_PUSH
    } lvl_op_t;

    typedef struct packed {
        logic    start;
        lvl_op_t op;
    } lvl_cmd_t;

    typedef struct packed {
        logic busy;
        logic hit;
        logic lru_hit;
        logic free_ok;
    } lvl_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PDROP,
        ST_SETW,
        ST_HINS,
        ST_HDROP,
        ST_WINS,
        ST_WSCAN,
        ST_WDROP,
        ST_WPUSHD,
        ST_WPUSH,
        ST_HPUSHD,
        ST_HPUSH,
        ST_WAITFIN,
        ST_OUT
    } state_t;

    function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] c);
        count_inc = (c == COUNT_MAX) ? c : c + COUNT_ONE;
    endfunction

endpackage

// File: rtl/tlc_if.sv
interface tlc_req_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            operation;
    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;

    modport source (output valid, output operation, output req_key, output req_value,
                    input ready);
    modport sink (input valid, input operation, input req_key, input req_value,
                  output ready);
endinterface

interface tlc_rsp_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic                  found_level;
    logic [VALUE_BITS-1:0] read_value;
    logic                  victim_valid;
    logic [KEY_BITS-1:0]   victim_key;
    logic [VALUE_BITS-1:0] victim_value;

    modport source (output valid, output found, output found_level, output read_value,
                    output victim_valid, output victim_key, output victim_value,
                    input ready);
    modport sink (input valid, input found, input found_level, input read_value,
                  input victim_valid, input victim_key, input victim_value,
                  output ready);
endinterface

// File: rtl/two_level_lru_cache_promotion.sv
// Each request takes a sequence of passes over the level memories, one entry per cycle.
// The first pass of a request scans both levels together.
// A request is accepted only in the idle state, and a new one is taken from the cycle
// after the response is loaded into the output registers.
// Reset clears valid bits, fills, the response valid and control state, and sets the
// configuration to its defaults; memories stay undefined.
module two_level_lru_cache_promotion #(
    parameter int HOT_ENTRIES  = 16,
    parameter int WARM_ENTRIES = 64,
    parameter int KEY_BITS     = 32,
    parameter int VALUE_BITS   = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    tlc_req_if.sink    req,
    tlc_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import tlc_pkg::*;

    localparam int HIW = (HOT_ENTRIES > 1) ? $clog2(HOT_ENTRIES) : 1;
    localparam int WIW = (WARM_ENTRIES > 1) ? $clog2(WARM_ENTRIES) : 1;
    localparam int HFW = $clog2(HOT_ENTRIES + 1);
    localparam int WFW = $clog2(WARM_ENTRIES + 1);

    state_t state_reg, state_next;

    logic [4:0] hot_limit_reg;
    logic [6:0] warm_limit_reg;
    logic [7:0] thr_reg;

    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg, ins_value_reg;
    logic                  res_found_reg, res_level_reg, res_vict_reg;
    logic [VALUE_BITS-1:0] res_rd_reg, res_vval_reg;
    logic [KEY_BITS-1:0]   res_vkey_reg;
    logic                  out_valid_reg;
    logic                  out_found_reg, out_level_reg, out_vict_reg;
    logic [VALUE_BITS-1:0] out_rd_reg, out_vval_reg;
    logic [KEY_BITS-1:0]   out_vkey_reg;

    lvl_cmd_t              hot_cmd, warm_cmd;
    lvl_stat_t             hot_stat, warm_stat;
    logic [HIW-1:0]        hot_idx, hot_rank;
    logic [WIW-1:0]        warm_idx, warm_rank;
    logic [KEY_BITS-1:0]   hot_key, warm_key;
    logic [VALUE_BITS-1:0] hot_value, warm_value;
    logic [COUNT_BITS-1:0] hot_count, warm_count;

    logic [HIW-1:0]        h_hit_idx, h_hit_rank, h_lru_idx, h_free_idx;
    logic [VALUE_BITS-1:0] h_hit_value, h_lru_value;
    logic [COUNT_BITS-1:0] h_hit_count, h_lru_count;
    logic [KEY_BITS-1:0]   h_lru_key;
    logic [HFW-1:0]        hot_fill;
    logic [WIW-1:0]        w_hit_idx, w_hit_rank, w_lru_idx, w_free_idx;
    logic [VALUE_BITS-1:0] w_hit_value, w_lru_value;
    logic [COUNT_BITS-1:0] w_hit_count, w_lru_count;
    logic [KEY_BITS-1:0]   w_lru_key;
    logic [WFW-1:0]        warm_fill;

    logic [HFW-1:0]        hlim;
    logic [WFW-1:0]        wlim;
    logic                  hot_full, warm_full;
    logic [COUNT_BITS-1:0] w_new_count;
    logic                  load_res, set_victim, load_out;

    tlc_level #(.DEPTH(HOT_ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
                .IW(HIW), .FW(HFW)) u_hot (
        .clk (clk), .rst_n (rst_n), .cmd (hot_cmd), .cmd_idx (hot_idx),
        .cmd_rank (hot_rank), .cmd_key (hot_key), .cmd_value (hot_value),
        .cmd_count (hot_count), .stat (hot_stat), .hit_idx (h_hit_idx),
        .hit_rank (h_hit_rank), .hit_value (h_hit_value), .hit_count (h_hit_count),
        .lru_idx (h_lru_idx), .lru_key (h_lru_key), .lru_value (h_lru_value),
        .lru_count (h_lru_count), .free_idx (h_free_idx), .fill (hot_fill)
    );

    tlc_level #(.DEPTH(WARM_ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
                .IW(WIW), .FW(WFW)) u_warm (
        .clk (clk), .rst_n (rst_n), .cmd (warm_cmd), .cmd_idx (warm_idx),
        .cmd_rank (warm_rank), .cmd_key (warm_key), .cmd_value (warm_value),
        .cmd_count (warm_count), .stat (warm_stat), .hit_idx (w_hit_idx),
        .hit_rank (w_hit_rank), .hit_value (w_hit_value), .hit_count (w_hit_count),
        .lru_idx (w_lru_idx), .lru_key (w_lru_key), .lru_value (w_lru_value),
        .lru_count (w_lru_count), .free_idx (w_free_idx), .fill (warm_fill)
    );

    always_comb
    begin
        if (hot_limit_reg == '0)
            hlim = HFW'(1);
        else if (32'(hot_limit_reg) > HOT_ENTRIES)
            hlim = HFW'(HOT_ENTRIES);
        else
            hlim = HFW'(hot_limit_reg);
        if (warm_limit_reg == '0)
            wlim = WFW'(1);
        else if (32'(warm_limit_reg) > WARM_ENTRIES)
            wlim = WFW'(WARM_ENTRIES);
        else
            wlim = WFW'(warm_limit_reg);
    end

    assign hot_full    = (hot_fill >= hlim) && (hot_fill != '0);
    assign warm_full   = (warm_fill >= wlim) && (warm_fill != '0);
    assign w_new_count = count_inc(w_hit_count);

    always_comb
    begin
        state_next = state_reg;
        hot_cmd    = '{start: 1'b0, op: LOP_SCAN};
        warm_cmd   = '{start: 1'b0, op: LOP_SCAN};
        hot_idx    = h_hit_idx;
        hot_rank   = h_hit_rank;
        hot_key    = key_reg;
        hot_value  = h_hit_value;
        hot_count  = count_inc(h_hit_count);
        warm_idx   = w_hit_idx;
        warm_rank  = w_hit_rank;
        warm_key   = key_reg;
        warm_value = w_hit_value;
        warm_count = w_new_count;
        load_res   = 1'b0;
        set_victim = 1'b0;
        load_out   = 1'b0;
        req.ready  = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    hot_cmd   = '{start: 1'b1, op: LOP_SCAN};
                    warm_cmd  = '{start: 1'b1, op: LOP_SCAN};
                    hot_key   = req.req_key;
                    warm_key  = req.req_key;
                    hot_rank  = HIW'(hot_fill - HFW'(1));
                    warm_rank = WIW'(warm_fill - WFW'(1));
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!hot_stat.busy && !warm_stat.busy)
                begin
                    load_res = 1'b1;
                    priority if (op_reg == OP_GET && hot_stat.hit)
                    begin
                        hot_cmd = '{start: 1'b1, op: LOP_TOUCH};
                        state_next = ST_WAITFIN;
                    end
                    else if (op_reg == OP_GET && warm_stat.hit)
                    begin
                        if (w_new_count >= thr_reg)
                        begin
                            warm_cmd = '{start: 1'b1, op: LOP_DROP};
                            state_next = ST_PDROP;
                        end
                        else
                        begin
                            warm_cmd = '{start: 1'b1, op: LOP_TOUCH};
                            state_next = ST_WAITFIN;
                        end
                    end
                    else if (op_reg == OP_SET && warm_stat.hit)
                    begin
                        warm_cmd = '{start: 1'b1, op: LOP_DROP};
                        state_next = ST_SETW;
                    end
                    else if (op_reg == OP_SET && hot_stat.hit)
                    begin
                        hot_cmd   = '{start: 1'b1, op: LOP_TOUCH};
                        hot_value = val_reg;
                        hot_count = COUNT_ONE;
                        state_next = ST_WAITFIN;
                    end
                    else if (op_reg == OP_SET)
                    begin
                        state_next = ST_HINS;
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        hot_cmd  = '{start: hot_stat.hit, op: LOP_DROP};
                        warm_cmd = '{start: warm_stat.hit, op: LOP_DROP};
                        state_next = ST_WAITFIN;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_PDROP:
            begin
                if (!warm_stat.busy)
                    state_next = ST_HINS;
            end
            ST_SETW:
            begin
                if (!warm_stat.busy)
                begin
                    if (hot_stat.hit)
                    begin
                        hot_cmd   = '{start: 1'b1, op: LOP_TOUCH};
                        hot_value = val_reg;
                        hot_count = COUNT_ONE;
                        state_next = ST_WAITFIN;
                    end
                    else
                    begin
                        state_next = ST_HINS;
                    end
                end
            end
            ST_HINS:
            begin
                if (hot_full && hot_stat.lru_hit)
                begin
                    hot_cmd  = '{start: 1'b1, op: LOP_DROP};
                    hot_idx  = h_lru_idx;
                    hot_rank = HIW'(hot_fill - HFW'(1));
                    state_next = ST_HDROP;
                end
                else
                begin
                    state_next = ST_HPUSHD;
                end
            end
            ST_HDROP:
            begin
                if (!hot_stat.busy)
                    state_next = ST_WINS;
            end
            ST_WINS:
            begin
                if (warm_full)
                begin
                    warm_cmd  = '{start: 1'b1, op: LOP_SCAN};
                    warm_rank = WIW'(warm_fill - WFW'(1));
                    state_next = ST_WSCAN;
                end
                else
                begin
                    state_next = ST_WPUSHD;
                end
            end
            ST_WSCAN:
            begin
                if (!warm_stat.busy)
                begin
                    if (warm_stat.lru_hit)
                    begin
                        set_victim = 1'b1;
                        warm_cmd  = '{start: 1'b1, op: LOP_DROP};
                        warm_idx  = w_lru_idx;
                        warm_rank = WIW'(warm_fill - WFW'(1));
                        state_next = ST_WDROP;
                    end
                    else
                    begin
                        state_next = ST_WPUSHD;
                    end
                end
            end
            ST_WDROP:
            begin
                if (!warm_stat.busy)
                    state_next = ST_WPUSHD;
            end
            ST_WPUSHD:
            begin
                if (warm_stat.free_ok)
                begin
                    warm_cmd   = '{start: 1'b1, op: LOP_PUSH};
                    warm_idx   = w_free_idx;
                    warm_key   = h_lru_key;
                    warm_value = h_lru_value;
                    warm_count = h_lru_count;
                    state_next = ST_WPUSH;
                end
                else
                begin
                    state_next = ST_HPUSHD;
                end
            end
            ST_WPUSH:
            begin
                if (!warm_stat.busy)
                    state_next = ST_HPUSHD;
            end
            ST_HPUSHD:
            begin
                if (hot_stat.free_ok)
                begin
                    hot_cmd   = '{start: 1'b1, op: LOP_PUSH};
                    hot_idx   = h_free_idx;
                    hot_value = ins_value_reg;
                    hot_count = COUNT_ONE;
                    state_next = ST_HPUSH;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_HPUSH:
            begin
                if (!hot_stat.busy)
                    state_next = ST_OUT;
            end
            ST_WAITFIN:
            begin
                if (!hot_stat.busy && !warm_stat.busy)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hot_limit_reg  <= 5'd16;
            warm_limit_reg <= 7'd64;
            thr_reg        <= 8'd3;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_HOT_LIMIT)
                    hot_limit_reg <= cfg_data[4:0];
                else if (cfg_index == CFG_WARM_LIMIT)
                    warm_limit_reg <= cfg_data[6:0];
                else if (cfg_index == CFG_PROMOTE_THR)
                    thr_reg <= cfg_data;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg  <= req.operation;
            key_reg <= req.req_key;
            val_reg <= req.req_value;
        end
        if (load_res)
        begin
            res_vict_reg <= 1'b0;
            res_vkey_reg <= '0;
            res_vval_reg <= '0;
            res_found_reg <= 1'b0;
            res_level_reg <= 1'b0;
            res_rd_reg    <= '0;
            ins_value_reg <= val_reg;
            if (op_reg == OP_GET && hot_stat.hit)
            begin
                res_found_reg <= 1'b1;
                res_rd_reg    <= h_hit_value;
            end
            else if (op_reg == OP_GET && warm_stat.hit)
            begin
                res_found_reg <= 1'b1;
                res_level_reg <= 1'b1;
                res_rd_reg    <= w_hit_value;
                ins_value_reg <= w_hit_value;
            end
            else if (op_reg == OP_REMOVE)
            begin
                res_found_reg <= hot_stat.hit || warm_stat.hit;
                res_level_reg <= !hot_stat.hit && warm_stat.hit;
            end
        end
        if (set_victim)
        begin
            res_vict_reg <= 1'b1;
            res_vkey_reg <= w_lru_key;
            res_vval_reg <= w_lru_value;
        end
        if (load_out)
        begin
            out_found_reg <= res_found_reg;
            out_level_reg <= res_level_reg;
            out_rd_reg    <= res_rd_reg;
            out_vict_reg  <= res_vict_reg;
            out_vkey_reg  <= res_vkey_reg;
            out_vval_reg  <= res_vval_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.found_level  = out_level_reg;
    assign rsp.read_value   = out_rd_reg;
    assign rsp.victim_valid = out_vict_reg;
    assign rsp.victim_key   = out_vkey_reg;
    assign rsp.victim_value = out_vval_reg;

    a_idle_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!hot_stat.busy && !warm_stat.busy))
        else $error("level pass still running while idle");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_SCAN && hot_stat.busy))
        else $error("accepted transfer did not start a scan");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(hot_fill) <= HOT_ENTRIES) && (32'(warm_fill) <= WARM_ENTRIES))
        else $error("level fill out of range");

    a_level_found: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (!rsp.found_level || rsp.found))
        else $error("hit level without a hit");
endmodule

// File: rtl/tlc_ram.sv
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/tlc_level.sv
module tlc_level #(
    parameter int DEPTH      = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int IW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int FW         = $clog2(DEPTH + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tlc_pkg::lvl_cmd_t              cmd,
    input  logic [IW-1:0]                  cmd_idx,
    input  logic [IW-1:0]                  cmd_rank,
    input  logic [KEY_BITS-1:0]            cmd_key,
    input  logic [VALUE_BITS-1:0]          cmd_value,
    input  logic [tlc_pkg::COUNT_BITS-1:0] cmd_count,
    output tlc_pkg::lvl_stat_t             stat,
    output logic [IW-1:0]                  hit_idx,
    output logic [IW-1:0]                  hit_rank,
    output logic [VALUE_BITS-1:0]          hit_value,
    output logic [tlc_pkg::COUNT_BITS-1:0] hit_count,
    output logic [IW-1:0]                  lru_idx,
    output logic [KEY_BITS-1:0]            lru_key,
    output logic [VALUE_BITS-1:0]          lru_value,
    output logic [tlc_pkg::COUNT_BITS-1:0] lru_count,
    output logic [IW-1:0]                  free_idx,
    output logic [FW-1:0]                  fill
);
    import tlc_pkg::*;

    localparam int WW = KEY_BITS + VALUE_BITS + COUNT_BITS + IW;
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    logic                  valid_reg [DEPTH];
    logic [FW-1:0]         fill_reg;
    logic                  busy_reg, issue_reg, pend_reg;
    logic [IW-1:0]         ptr_reg, rd_idx_reg;
    lvl_op_t               op_reg;
    logic [IW-1:0]         idx_reg, rank_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  hit_reg, lru_hit_reg;

    logic                  we;
    logic [WW-1:0]         wdata, rdata;
    logic [KEY_BITS-1:0]   e_key;
    logic [VALUE_BITS-1:0] e_value;
    logic [COUNT_BITS-1:0] e_count;
    logic [IW-1:0]         e_rank;
    logic                  e_valid;
    logic                  free_found;
    logic [IW-1:0]         free_sel;

    tlc_ram #(.WIDTH(WW), .DEPTH(DEPTH), .AW(IW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (rd_idx_reg),
        .wdata (wdata),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    assign {e_key, e_value, e_count, e_rank} = rdata;
    assign e_valid = valid_reg[rd_idx_reg];

    always_comb
    begin
        we    = 1'b0;
        wdata = rdata;
        if (busy_reg && pend_reg)
        begin
            unique case (op_reg)
                LOP_SCAN:
                begin
                    we = 1'b0;
                end
                LOP_TOUCH:
                begin
                    we = e_valid;
                    if (rd_idx_reg == idx_reg)
                    begin
                        wdata = {e_key, value_reg, count_reg, IW'(0)};
                    end
                    else if (e_rank < rank_reg)
                    begin
                        wdata = {e_key, e_value, e_count, e_rank + IW'(1)};
                    end
                end
                LOP_DROP:
                begin
                    we = e_valid && (e_rank > rank_reg);
                    wdata = {e_key, e_value, e_count, e_rank - IW'(1)};
                end
                LOP_PUSH:
                begin
                    if (rd_idx_reg == idx_reg)
                    begin
                        we = 1'b1;
                        wdata = {key_reg, value_reg, count_reg, IW'(0)};
                    end
                    else
                    begin
                        we = e_valid;
                        wdata = {e_key, e_value, e_count, e_rank + IW'(1)};
                    end
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        free_found = 1'b0;
        free_sel   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_sel   = IW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            fill_reg    <= '0;
            busy_reg    <= 1'b0;
            issue_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            ptr_reg     <= '0;
            hit_reg     <= 1'b0;
            lru_hit_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            busy_reg  <= 1'b1;
            issue_reg <= 1'b1;
            pend_reg  <= 1'b0;
            ptr_reg   <= '0;
            if (cmd.op == LOP_SCAN)
            begin
                hit_reg     <= 1'b0;
                lru_hit_reg <= 1'b0;
            end
            if (cmd.op == LOP_DROP)
            begin
                valid_reg[cmd_idx] <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (issue_reg)
            begin
                pend_reg <= 1'b1;
                if (ptr_reg == LAST)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    ptr_reg <= ptr_reg + IW'(1);
                end
            end
            else
            begin
                pend_reg <= 1'b0;
            end
            if (pend_reg)
            begin
                if (op_reg == LOP_SCAN && e_valid)
                begin
                    if (!hit_reg && e_key == key_reg)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (!lru_hit_reg && e_rank == rank_reg)
                    begin
                        lru_hit_reg <= 1'b1;
                    end
                end
                if (rd_idx_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    if (op_reg == LOP_PUSH)
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        fill_reg <= fill_reg + FW'(1);
                    end
                    else if (op_reg == LOP_DROP && fill_reg != '0)
                    begin
                        fill_reg <= fill_reg - FW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg    <= cmd.op;
            idx_reg   <= cmd_idx;
            rank_reg  <= cmd_rank;
            key_reg   <= cmd_key;
            value_reg <= cmd_value;
            count_reg <= cmd_count;
        end
        if (busy_reg && issue_reg)
        begin
            rd_idx_reg <= ptr_reg;
        end
        if (busy_reg && pend_reg && op_reg == LOP_SCAN && e_valid)
        begin
            if (!hit_reg && e_key == key_reg)
            begin
                hit_idx   <= rd_idx_reg;
                hit_rank  <= e_rank;
                hit_value <= e_value;
                hit_count <= e_count;
            end
            if (!lru_hit_reg && e_rank == rank_reg)
            begin
                lru_idx   <= rd_idx_reg;
                lru_key   <= e_key;
                lru_value <= e_value;
                lru_count <= e_count;
            end
        end
    end

    assign stat.busy    = busy_reg;
    assign stat.hit     = hit_reg;
    assign stat.lru_hit = lru_hit_reg;
    assign stat.free_ok = free_found;
    assign free_idx     = free_sel;
    assign fill         = fill_reg;
endmodule
